// ===== rtl/pdr_pkg.sv =====
// Shared constants, codes and types of the priority deque ring.
package pdr_pkg;

  localparam int unsigned DEPTH_DEF  = 32;
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned TAG_W      = 32;
  localparam int unsigned AGE_W      = 8;
  localparam int unsigned SLOT_W     = 5;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned ST_W       = 2;

  localparam logic [AGE_W-1:0] PRIORITY_AGE_RESET = 8'd60;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LIST   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    CMD_INS_FRONT,
    CMD_INS_BACK,
    CMD_REMOVE,
    CMD_LIST
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } cmd_t;

endpackage

// ===== rtl/pdr_ifs.sv =====
// Handshake interfaces for the input, result and configuration channels.
interface pdr_in_if;
  import pdr_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [TAG_W-1:0] entry_tag;
  logic [AGE_W-1:0] entry_age;
  modport source (output valid, output op, output entry_tag, output entry_age, input ready);
  modport sink   (input valid, input op, input entry_tag, input entry_age, output ready);
endinterface

interface pdr_out_if;
  import pdr_pkg::*;
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [TAG_W-1:0]  out_tag;
  logic [AGE_W-1:0]  out_age;
  logic [SLOT_W-1:0] slot_index;
  logic              last;
  modport source (output valid, output status, output out_tag, output out_age,
                  output slot_index, output last, input ready);
  modport sink   (input valid, input status, input out_tag, input out_age,
                  input slot_index, input last, output ready);
endinterface

interface pdr_cfg_if;
  import pdr_pkg::*;
  logic             valid;
  logic             ready;
  logic [AGE_W-1:0] priority_age;
  modport source (output valid, output priority_age, input ready);
  modport sink   (input valid, input priority_age, output ready);
endinterface

// ===== rtl/pdr_front.sv =====
// Front end: takes input words, holds the threshold and classifies commands.
module pdr_front (
  input  logic          clk,
  input  logic          rst_n,
  pdr_in_if.sink        in_ch,
  pdr_cfg_if.sink       cfg_ch,
  output logic          push_valid,
  output pdr_pkg::cmd_t push_cmd,
  input  logic          push_ready
);
  import pdr_pkg::*;

  logic [AGE_W-1:0] priority_age_r;
  logic [AGE_W-1:0] priority_age_nxt;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = push_ready;

  always_comb begin
    priority_age_nxt = priority_age_r;
    if (cfg_ch.valid) begin
      priority_age_nxt = cfg_ch.priority_age;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      priority_age_r <= PRIORITY_AGE_RESET;
    end else begin
      priority_age_r <= priority_age_nxt;
    end
  end

  always_comb begin
    push_cmd.tag  = in_ch.entry_tag;
    push_cmd.age  = in_ch.entry_age;
    push_cmd.kind = CMD_LIST;
    push_valid    = 1'b0;
    case (in_ch.op)
      OP_INSERT: begin
        push_valid    = in_ch.valid;
        push_cmd.kind = (in_ch.entry_age >= priority_age_r) ? CMD_INS_FRONT : CMD_INS_BACK;
      end
      OP_REMOVE: begin
        push_valid    = in_ch.valid;
        push_cmd.kind = CMD_REMOVE;
      end
      OP_LIST: begin
        push_valid    = in_ch.valid;
        push_cmd.kind = CMD_LIST;
      end
      default: begin
        push_valid = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/pdr_cmdq.sv =====
// Short command queue between the front end and the deque engine.
module pdr_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  pdr_pkg::cmd_t push_cmd,
  output logic          push_ready,
  output logic          pop_valid,
  output pdr_pkg::cmd_t pop_cmd,
  input  logic          pop_ready
);
  import pdr_pkg::*;

  localparam int unsigned QPW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned QCW = $clog2(CMDQ_DEPTH + 1);

  cmd_t           entries_r [CMDQ_DEPTH];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;
  logic           push_fire;
  logic           pop_fire;

  assign push_ready = (count_r != QCW'(CMDQ_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entries_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + QPW'(1);
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + QPW'(1);
    end
    if (push_fire && !pop_fire) begin
      count_nxt = count_r + QCW'(1);
    end else if (pop_fire && !push_fire) begin
      count_nxt = count_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/pdr_back.sv =====
// Deque engine: ring pointers, slot memory and result register.
module pdr_back #(
  parameter int unsigned DEPTH = pdr_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  input  pdr_pkg::cmd_t pop_cmd,
  output logic          pop_ready,
  pdr_out_if.source     out_ch
);
  import pdr_pkg::*;

  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned WORD_W = TAG_W + AGE_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
    return (p == '0) ? PW'(DEPTH - 1) : p - PW'(1);
  endfunction

  state_t            state_r, state_nxt;
  logic [PW-1:0]     front_r, front_nxt;
  logic [PW-1:0]     back_r, back_nxt;
  logic [PW-1:0]     idx_r, idx_nxt;
  logic              list_r, list_nxt;
  logic [ST_W-1:0]   st_r, st_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic [AGE_W-1:0]  age_r, age_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              last_r, last_nxt;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;
  logic              wr_en, rd_en;
  logic [PW-1:0]     wr_addr, rd_addr;
  logic [WORD_W-1:0] wr_data;

  logic              full, empty, pop_fire;

  assign full      = (ring_next(back_r) == front_r);
  assign empty     = (front_r == back_r);
  assign pop_ready = (state_r == S_IDLE);
  assign pop_fire  = pop_valid && pop_ready;

  assign out_ch.valid      = (state_r == S_OUT);
  assign out_ch.status     = st_r;
  assign out_ch.out_tag    = tag_r;
  assign out_ch.out_age    = age_r;
  assign out_ch.slot_index = slot_r;
  assign out_ch.last       = last_r;

  always_comb begin
    state_nxt = state_r;
    front_nxt = front_r;
    back_nxt  = back_r;
    idx_nxt   = idx_r;
    list_nxt  = list_r;
    st_nxt    = st_r;
    tag_nxt   = tag_r;
    age_nxt   = age_r;
    slot_nxt  = slot_r;
    last_nxt  = last_r;
    wr_en     = 1'b0;
    wr_addr   = front_r;
    wr_data   = {pop_cmd.tag, pop_cmd.age};
    rd_en     = 1'b0;
    rd_addr   = ring_next(front_r);
    case (state_r)
      S_IDLE: begin
        if (pop_valid) begin
          st_nxt   = ST_OK;
          tag_nxt  = '0;
          age_nxt  = '0;
          slot_nxt = '0;
          last_nxt = 1'b1;
          state_nxt = S_OUT;
          case (pop_cmd.kind)
            CMD_INS_FRONT: begin
              if (full) begin
                st_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = front_r;
                front_nxt = ring_prev(front_r);
              end
            end
            CMD_INS_BACK: begin
              if (full) begin
                st_nxt = ST_FULL;
              end else begin
                wr_en    = 1'b1;
                wr_addr  = ring_next(back_r);
                back_nxt = ring_next(back_r);
              end
            end
            CMD_REMOVE: begin
              if (empty) begin
                st_nxt = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                front_nxt = ring_next(front_r);
                idx_nxt   = ring_next(front_r);
                list_nxt  = 1'b0;
                state_nxt = S_RD;
              end
            end
            default: begin
              if (empty) begin
                st_nxt = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                idx_nxt   = ring_next(front_r);
                list_nxt  = 1'b1;
                state_nxt = S_RD;
              end
            end
          endcase
        end
      end
      S_RD: begin
        st_nxt    = ST_OK;
        tag_nxt   = rd_data_r[WORD_W-1:AGE_W];
        age_nxt   = rd_data_r[AGE_W-1:0];
        slot_nxt  = list_r ? SLOT_W'(idx_r) : '0;
        last_nxt  = !list_r || (idx_r == back_r);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ch.ready) begin
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = ring_next(idx_r);
            idx_nxt   = ring_next(idx_r);
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= PW'(DEPTH - 1);
      back_r  <= PW'(DEPTH - 1);
      list_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      back_r  <= back_nxt;
      list_r  <= list_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    st_r   <= st_nxt;
    tag_r  <= tag_nxt;
    age_r  <= age_nxt;
    slot_r <= slot_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  a_rd_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD |=> state_r == S_OUT)
    else $error("read stage not followed by result");

  a_full_keeps_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_fire && full && (pop_cmd.kind == CMD_INS_FRONT || pop_cmd.kind == CMD_INS_BACK))
    |=> ($stable(front_r) && $stable(back_r)))
    else $error("refused insert moved a pointer");

  a_remove_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_fire && !empty && pop_cmd.kind == CMD_REMOVE)
    |=> (front_r == ring_next($past(front_r)) && $stable(back_r)))
    else $error("remove did not step the front pointer");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> state_r == S_IDLE)
    else $error("engine busy after final result");

endmodule

// ===== rtl/priority_deque_ring_unit.sv =====
// Top level of the priority deque ring: front end, command queue and engine.
// A ring of DEPTH slots holding up to DEPTH-1 tagged entries. Inserts whose age is at or above
// the configured threshold go in at the front, others at the back; removes take the front
// entry; a list emits every entry front to back with its slot. Input words are taken into a
// two-deep command queue, so the input side keeps accepting while a result waits until the
// queue is full. The engine takes one command at a time: an insert goes straight to the result
// register, while a remove and each listed entry pass through the registered read of the
// single-port slot memory and the result register. No clearing pass is needed after reset.
module priority_deque_ring_unit #(
  parameter int unsigned DEPTH = pdr_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pdr_in_if.sink    in_ch,
  pdr_out_if.source out_ch,
  pdr_cfg_if.sink   cfg_ch
);
  import pdr_pkg::*;

  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  pdr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  pdr_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  pdr_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for priority_deque_ring_unit: directed then random deque traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pdr_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEF;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int unsigned IDLE_MAX = 17;
  localparam int unsigned SETTLE = 80;
  localparam int unsigned STALL_LIMIT = 3000;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
    bit               hold;
  } word_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [TAG_W-1:0]  tag;
    logic [AGE_W-1:0]  age;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } result_t;

  logic clk;
  logic rst_n;

  pdr_in_if  in_ch ();
  pdr_out_if out_ch ();
  pdr_cfg_if cfg_ch ();

  priority_deque_ring_unit #(.DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // deque mirror
  logic [TAG_W-1:0] ring_tag [DEPTH];
  logic [AGE_W-1:0] ring_age [DEPTH];
  int unsigned      head = DEPTH - 1;
  int unsigned      tail = DEPTH - 1;
  logic [AGE_W-1:0] urgent_age = PRIORITY_AGE_RESET;

  word_t   words_to_send [$];
  result_t want_results [$];

  bit          in_acc, out_acc;
  bit          tx_idle_en, rx_idle_en;
  int unsigned tx_wait, rx_wait;
  int unsigned errors, words_in, results_seen, cfg_writes, refusals, longest_list;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned ring_inc(int unsigned p);
    return (p + 1) % DEPTH;
  endfunction

  function automatic int unsigned ring_dec(int unsigned p);
    return (p + DEPTH - 1) % DEPTH;
  endfunction

  function automatic int unsigned idle_draw(bit en);
    return en ? $urandom_range(0, IDLE_MAX) : 0;
  endfunction

  function automatic void push_result(logic [ST_W-1:0] st, logic [TAG_W-1:0] tg,
                                      logic [AGE_W-1:0] ag, logic [SLOT_W-1:0] sl, logic lst);
    result_t r;
    r = '{status: st, tag: tg, age: ag, slot: sl, last: lst};
    want_results.push_back(r);
  endfunction

  function automatic void apply_deque_op(logic [OP_W-1:0] op, logic [TAG_W-1:0] tg,
                                         logic [AGE_W-1:0] ag);
    int unsigned i, n;
    case (op)
      OP_INSERT: begin
        if (ring_inc(tail) == head) begin
          refusals++;
          push_result(ST_FULL, '0, '0, '0, 1'b1);
        end else begin
          if (ag >= urgent_age) begin
            ring_tag[head] = tg;
            ring_age[head] = ag;
            head = ring_dec(head);
          end else begin
            tail = ring_inc(tail);
            ring_tag[tail] = tg;
            ring_age[tail] = ag;
          end
          push_result(ST_OK, '0, '0, '0, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (head == tail) begin
          push_result(ST_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          head = ring_inc(head);
          push_result(ST_OK, ring_tag[head], ring_age[head], '0, 1'b1);
        end
      end
      OP_LIST: begin
        if (head == tail) begin
          push_result(ST_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          n = 0;
          for (i = ring_inc(head); i != ring_inc(tail); i = ring_inc(i)) begin
            push_result(ST_OK, ring_tag[i], ring_age[i], SLOT_W'(i),
                        ring_inc(i) == ring_inc(tail));
            n++;
          end
          if (n > longest_list) longest_list = n;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic flag(string what, logic [63:0] got, logic [63:0] exp);
    errors++;
    $display("ERROR @%0t: %s got %0h expected %0h", $time, what, got, exp);
  endtask

  task automatic take_result();
    result_t want;
    results_seen++;
    if (want_results.size() == 0) begin
      flag("result word with nothing expected, tag", out_ch.out_tag, 0);
      return;
    end
    want = want_results.pop_front();
    if (out_ch.status !== want.status) flag("status", out_ch.status, want.status);
    if (out_ch.out_tag !== want.tag) flag("out_tag", out_ch.out_tag, want.tag);
    if (out_ch.out_age !== want.age) flag("out_age", out_ch.out_age, want.age);
    if (out_ch.slot_index !== want.slot) flag("slot_index", out_ch.slot_index, want.slot);
    if (out_ch.last !== want.last) flag("last", out_ch.last, want.last);
  endtask

  // sample at the rising edge
  always @(posedge clk) begin
    in_acc  <= in_ch.valid && in_ch.ready;
    out_acc <= out_ch.valid && out_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      words_in++;
      apply_deque_op(in_ch.op, in_ch.entry_tag, in_ch.entry_age);
    end
    if (rst_n && out_ch.valid && out_ch.ready) take_result();
  end

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      tx_wait     <= 0;
    end else if (!in_ch.valid || in_acc) begin
      if (tx_wait != 0) begin
        in_ch.valid <= 1'b0;
        tx_wait     <= tx_wait - 1;
      end else if (words_to_send.size() != 0 &&
                   !(words_to_send[0].hold && want_results.size() != 0)) begin
        in_ch.op        <= words_to_send[0].op;
        in_ch.entry_tag <= words_to_send[0].tag;
        in_ch.entry_age <= words_to_send[0].age;
        in_ch.valid     <= 1'b1;
        tx_wait         <= idle_draw(tx_idle_en);
        void'(words_to_send.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result sink with random back-pressure
  always @(negedge clk) begin : rx_side
    int unsigned w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait      <= 0;
    end else if (out_ch.ready && out_acc) begin
      w = idle_draw(rx_idle_en);
      if (w != 0) begin
        out_ch.ready <= 1'b0;
        rx_wait      <= w - 1;
      end
    end else if (!out_ch.ready) begin
      if (rx_wait != 0) rx_wait <= rx_wait - 1;
      else out_ch.ready <= 1'b1;
    end
  end

  task automatic queue_word(logic [OP_W-1:0] op, logic [TAG_W-1:0] tg,
                            logic [AGE_W-1:0] ag, bit hold);
    word_t w;
    w = '{op: op, tag: tg, age: ag, hold: hold};
    words_to_send.push_back(w);
  endtask

  function automatic logic [AGE_W-1:0] pick_age();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return urgent_age;
      3:       return urgent_age - AGE_W'(1);
      default: return AGE_W'($urandom);
    endcase
  endfunction

  task automatic queue_random(int unsigned count);
    int unsigned made, k, pick;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 11);
      if (pick < 2) begin
        k = $urandom_range(8, 34);
        repeat (k) queue_word(OP_INSERT, $urandom, pick_age(), $urandom_range(0, 24) == 0);
        made += k;
      end else if (pick == 2) begin
        k = $urandom_range(4, 32);
        repeat (k) queue_word(OP_REMOVE, $urandom, AGE_W'($urandom), 1'b0);
        made += k;
      end else if (pick < 5) begin
        queue_word(OP_LIST, $urandom, AGE_W'($urandom), $urandom_range(0, 24) == 0);
        made++;
      end else if (pick == 5) begin
        queue_word(OP_SPARE, $urandom, AGE_W'($urandom), 1'b0);
      end else begin
        queue_word($urandom_range(0, 1) ? OP_INSERT : OP_REMOVE, $urandom, pick_age(),
                   $urandom_range(0, 24) == 0);
        made++;
      end
    end
  endtask

  task automatic wait_quiet();
    do @(posedge clk);
    while (words_to_send.size() != 0 || in_ch.valid || want_results.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_threshold(logic [AGE_W-1:0] v);
    @(negedge clk);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.priority_age <= v;
    do @(posedge clk);
    while (!cfg_ch.ready);
    urgent_age = v;
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.op            = OP_INSERT;
    in_ch.entry_tag     = '0;
    in_ch.entry_age     = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.priority_age = '0;
    tx_idle_en          = 1'b1;
    rx_idle_en          = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset threshold: empty cases, both insert ends, threshold boundary
    queue_word(OP_REMOVE, 32'h0, 8'h0, 1'b0);
    queue_word(OP_LIST, 32'hFFFF_FFFF, 8'hFF, 1'b0);
    queue_word(OP_SPARE, 32'hDEAD_BEEF, 8'h3C, 1'b0);
    queue_word(OP_INSERT, 32'h0, 8'h0, 1'b0);
    queue_word(OP_INSERT, 32'hFFFF_FFFF, 8'hFF, 1'b0);
    queue_word(OP_INSERT, 32'hA5A5_A5A5, urgent_age, 1'b0);
    queue_word(OP_INSERT, 32'h5A5A_5A5A, urgent_age - AGE_W'(1), 1'b0);
    queue_word(OP_LIST, 32'h0, 8'h0, 1'b0);
    queue_word(OP_REMOVE, 32'h0, 8'h0, 1'b1);
    repeat (3) queue_word(OP_REMOVE, 32'h0, 8'h0, 1'b0);
    queue_word(OP_REMOVE, 32'h0, 8'h0, 1'b0);
    queue_word(OP_LIST, 32'h0, 8'h0, 1'b0);
    queue_word(OP_INSERT, 32'h1234_5678, 8'h01, 1'b0);
    queue_word(OP_LIST, 32'h0, 8'h0, 1'b0);
    queue_word(OP_REMOVE, 32'h0, 8'h0, 1'b0);
    wait_quiet();

    // every age goes to the front; overfill to hit the full refusal
    write_threshold(8'h00);
    repeat (DEPTH + 1) queue_word(OP_INSERT, $urandom, pick_age(), 1'b0);
    queue_word(OP_LIST, 32'h0, 8'h0, 1'b0);
    queue_random(30);
    wait_quiet();

    write_threshold(8'hFF);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    queue_random(35);
    wait_quiet();

    write_threshold(AGE_W'($urandom_range(1, 254)));
    tx_idle_en = 1'b1;
    queue_random(35);
    wait_quiet();

    write_threshold(8'h01);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    queue_random(30);
    wait_quiet();

    while (want_results.size() != 0) begin
      flag("missing result word, status", 'x, want_results[0].status);
      void'(want_results.pop_front());
    end
    $display("Covered %0d input words and %0d result words over %0d threshold settings.",
             words_in, results_seen, cfg_writes + 1);
    $display("Full refusals: %0d, longest listing: %0d entries.", refusals, longest_list);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pdr_pkg.sv
rtl/pdr_ifs.sv
rtl/pdr_front.sv
rtl/pdr_cmdq.sv
rtl/pdr_back.sv
rtl/priority_deque_ring_unit.sv
dv/tb_top.sv
